FILE: rtl/whb_pkg.sv
package whb_pkg;

  localparam int unsigned MaxBins = 1024;
  localparam int unsigned IdxW    = 10;
  localparam int unsigned AccW    = 48;

  localparam logic [1:0] CmdAdd   = 2'd0;
  localparam logic [1:0] CmdRead  = 2'd1;
  localparam logic [1:0] CmdClear = 2'd2;

  localparam logic [1:0] StAdded   = 2'd0;
  localparam logic [1:0] StDropped = 2'd1;
  localparam logic [1:0] StRead    = 2'd2;
  localparam logic [1:0] StCleared = 2'd3;

  localparam logic [1:0] RegLowerBound = 2'd0;
  localparam logic [1:0] RegBinWidth   = 2'd1;
  localparam logic [1:0] RegBinCount   = 2'd2;

  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};

  // Saturating 48-bit signed add
  function automatic logic signed [AccW-1:0] sat_add(input logic signed [AccW-1:0] a,
                                                     input logic signed [AccW-1:0] b);
    logic signed [AccW:0] s;
    s = {a[AccW-1], a} + {b[AccW-1], b};
    if (s[AccW] != s[AccW-1]) sat_add = s[AccW] ? AccMin : AccMax;
    else sat_add = s[AccW-1:0];
  endfunction

endpackage

FILE: rtl/weighted_histogram_binner_unit.sv
// Fixed-width bin histogram with command interface.
// Commands enter on start_i when busy_o is low: add sample, read bin,
// clear all bins. Registers (lower bound, bin width, bin count) are written
// via cfg_we_i/cfg_idx_i/cfg_data_i by the user only while the unit is idle;
// the unit does not enforce this. Each command yields one result on the
// output ports, marked by done_o for one cycle; the receiver cannot stall it.
// Steps from the accepting edge to the edge that raises done_o:
//   add  : 33 restoring bin-index divide steps, range check, bin edge
//          multiply, memory read, modify/write, 4 integral, output;
//          a drop at the range check or before the divide skips to the integral
//   read : bin edge multiply, memory read, integral, output
//   clear: one store entry zeroed a cycle over all MaxBins entries, then output.
//   unused command: integral, output.
// busy_o falls with done_o, so the next command can be accepted while done_o
// is high; one command is in flight at a time.
// The integral (total times width, shifted right by 16) is built from two
// 32x31 partial products in S_INT1 and S_INT2.
// Reset: registers return to defaults and a clearing pass over all MaxBins
// entries zeroes the bin store; busy_o stays high during that pass.
module weighted_histogram_binner_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [1:0]          command_i,
  input  logic signed [31:0]  sample_i,
  input  logic                use_weight_i,
  input  logic signed [31:0]  weight_i,
  input  logic [9:0]          bin_select_i,
  output logic                done_o,
  output logic [1:0]          status_o,
  output logic [9:0]          bin_index_o,
  output logic signed [47:0]  bin_edge_o,
  output logic signed [47:0]  bin_total_o,
  output logic signed [47:0]  total_weight_o,
  output logic signed [63:0]  integral_o
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DIV, S_CHK, S_EDGE, S_RD, S_WR,
    S_INT0, S_INT1, S_INT2, S_INT3, S_OUT
  } state_e;

  state_e state_q;

  logic signed [31:0] lower_q;
  logic [30:0]        width_q;
  logic [10:0]        count_q;

  logic [1:0]         cmd_q;
  logic signed [47:0] amount_q;
  logic [32:0]        rem_q;
  logic [32:0]        quo_q;
  logic [32:0]        dvd_q;
  logic [5:0]         step_q;
  logic [9:0]         idx_q;
  logic [10:0]        clr_q;
  logic [1:0]         status_q;
  logic signed [47:0] edge_q;
  logic signed [47:0] content_q;
  logic signed [47:0] total_q;
  logic [47:0]        mag_q;
  logic [63:0]        prod_q;
  logic               neg_q;
  logic               sel_hi_q;

  // Bin store
  logic signed [47:0] mem_q [whb_pkg::MaxBins];
  logic signed [47:0] rd_q;
  logic               mem_we;
  logic [9:0]         mem_wa;
  logic signed [47:0] mem_wd;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    rd_q <= mem_q[idx_q];
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_q;
    mem_wd = '0;
    if (state_q == S_CLR) begin
      mem_we = 1'b1;
      mem_wa = clr_q[9:0];
    end else if (state_q == S_WR && cmd_q == whb_pkg::CmdAdd) begin
      mem_we = 1'b1;
      mem_wd = whb_pkg::sat_add(rd_q, amount_q);
    end
  end

  // Divider trial subtract
  logic [33:0] trial;
  logic [32:0] rem_sh;
  assign rem_sh = {rem_q[31:0], dvd_q[32]};
  assign trial  = {1'b0, rem_sh} - {3'b0, width_q};

  // Edge product and integral partial products
  logic [40:0] edge_prod;
  assign edge_prod = 41'(idx_q) * 41'(width_q);
  logic [31:0] mul_a;
  logic [63:0] mul_p;
  always_comb begin
    case (state_q)
      S_INT1:  mul_a = mag_q[47:16];
      default: mul_a = {16'b0, mag_q[15:0]};
    endcase
  end
  assign mul_p = 64'(mul_a) * 64'(width_q);

  logic signed [32:0] diff;
  assign diff = 33'(sample_i) - 33'(lower_q);
  logic [10:0] cnt_eff;
  assign cnt_eff = (count_q > 11'(whb_pkg::MaxBins)) ? 11'(whb_pkg::MaxBins) : count_q;

  assign busy_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      clr_q    <= '0;
      lower_q  <= '0;
      width_q  <= 31'd65536;
      count_q  <= 11'd1024;
      total_q  <= '0;
      cmd_q    <= whb_pkg::CmdAdd;
      status_q <= whb_pkg::StCleared;
      done_o   <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          whb_pkg::RegLowerBound: lower_q <= cfg_data_i;
          whb_pkg::RegBinWidth:   width_q <= cfg_data_i[30:0];
          whb_pkg::RegBinCount:   count_q <= cfg_data_i[10:0];
          default: ;
        endcase
      end
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 11'd1;
          if (clr_q == 11'(whb_pkg::MaxBins - 1)) state_q <= S_OUT;
          total_q <= '0;
        end
        S_IDLE: begin
          if (start_i) begin
            cmd_q     <= command_i;
            amount_q  <= use_weight_i ? 48'(weight_i) : 48'sd65536;
            status_q  <= whb_pkg::StDropped;
            edge_q    <= '0;
            content_q <= '0;
            idx_q     <= '0;
            case (command_i)
              whb_pkg::CmdAdd: begin
                if (cnt_eff >= 11'd2 && width_q != '0 && !diff[32]) begin
                  dvd_q   <= diff;
                  rem_q   <= '0;
                  step_q  <= '0;
                  state_q <= S_DIV;
                end else state_q <= S_INT0;
              end
              whb_pkg::CmdRead: begin
                idx_q    <= bin_select_i;
                sel_hi_q <= 1'b0;
                status_q <= whb_pkg::StRead;
                state_q  <= S_EDGE;
              end
              whb_pkg::CmdClear: begin
                clr_q    <= '0;
                status_q <= whb_pkg::StCleared;
                state_q  <= S_CLR;
              end
              default: state_q <= S_INT0;
            endcase
          end
        end
        S_DIV: begin
          // Restoring divide, one quotient bit a cycle
          dvd_q <= {dvd_q[31:0], 1'b0};
          if (!trial[33]) begin
            rem_q <= trial[32:0];
            quo_q <= {quo_q[31:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[31:0], 1'b0};
          end
          step_q <= step_q + 6'd1;
          if (step_q == 6'd32) state_q <= S_CHK;
        end
        S_CHK: begin
          if (quo_q < 33'(cnt_eff - 11'd1)) begin
            idx_q    <= quo_q[9:0];
            status_q <= whb_pkg::StAdded;
            state_q  <= S_EDGE;
          end else state_q <= S_INT0;
        end
        S_EDGE: begin
          edge_q  <= 48'(lower_q) + 48'(edge_prod);
          state_q <= S_RD;
        end
        S_RD: state_q <= S_WR;
        S_WR: begin
          if (cmd_q == whb_pkg::CmdAdd) begin
            content_q <= mem_wd;
            total_q   <= whb_pkg::sat_add(total_q, amount_q);
          end else content_q <= sel_hi_q ? '0 : rd_q;
          state_q <= S_INT0;
        end
        S_INT0: begin
          neg_q   <= total_q[47];
          mag_q   <= total_q[47] ? 48'(-total_q) : total_q;
          state_q <= S_INT1;
        end
        S_INT1: begin
          prod_q  <= mul_p;
          state_q <= S_INT2;
        end
        S_INT2: begin
          prod_q  <= prod_q + (mul_p >> 16);
          state_q <= S_INT3;
        end
        S_INT3: begin
          integral_o <= neg_q ? -prod_q : prod_q;
          state_q    <= S_OUT;
        end
        S_OUT: begin
          if (clr_q != 11'(whb_pkg::MaxBins) || status_q != whb_pkg::StCleared ||
              cmd_q == whb_pkg::CmdClear) begin
            status_o       <= status_q;
            bin_index_o    <= idx_q;
            bin_edge_o     <= edge_q;
            bin_total_o    <= content_q;
            total_weight_o <= total_q;
          end
          if (cmd_q == whb_pkg::CmdClear && status_q == whb_pkg::StCleared) begin
            integral_o <= '0;
            done_o     <= 1'b1;
          end else if (status_q != whb_pkg::StCleared) begin
            done_o <= 1'b1;
          end
          cmd_q    <= whb_pkg::CmdAdd;
          status_q <= whb_pkg::StDropped;
          state_q  <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: bench/tb_weighted_histogram_binner_unit.sv
module tb_weighted_histogram_binner_unit;

  localparam longint SatHi = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SatLo = -SatHi - 1;
  localparam int unsigned IdleLimit = 5000;
  localparam logic [1:0] CmdUnused = 2'd3;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] sample;
    logic        use_w;
    logic [31:0] weight;
    logic [9:0]  sel;
  } hist_cmd_t;

  typedef struct {
    logic [1:0]  status;
    logic [9:0]  index;
    logic [47:0] edge_v;
    logic [47:0] content;
    logic [47:0] total;
    logic [63:0] integ;
  } hist_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = whb_pkg::RegLowerBound;
  logic [31:0] cfg_data_i = '0;
  logic start_i = 1'b0;
  logic [1:0] command_i = whb_pkg::CmdAdd;
  logic signed [31:0] sample_i = '0;
  logic use_weight_i = 1'b0;
  logic signed [31:0] weight_i = '0;
  logic [9:0] bin_select_i = '0;
  logic busy_o, done_o;
  logic [1:0] status_o;
  logic [9:0] bin_index_o;
  logic signed [47:0] bin_edge_o, bin_total_o, total_weight_o;
  logic signed [63:0] integral_o;

  weighted_histogram_binner_unit dut (.*);

  always #10 clk_i = ~clk_i;

  // histogram shadow state
  longint lb_q, width_q, count_q;
  longint bins_q [whb_pkg::MaxBins];
  longint sum_q;

  hist_cmd_t pending_q [$];
  hist_res_t expected_q [$];
  int mismatches = 0;
  int unsigned idle_cycles = 0;
  logic taken = 1'b0;

  function automatic longint sat48(longint a, longint b);
    longint s;
    s = a + b;
    if (s > SatHi) return SatHi;
    if (s < SatLo) return SatLo;
    return s;
  endfunction

  function automatic longint area_of(longint tot, longint w);
    longint mag, prod;
    mag = (tot < 0) ? -tot : tot;
    prod = (mag >>> 16) * w + (((mag & 64'hFFFF) * w) >>> 16);
    return (tot < 0) ? -prod : prod;
  endfunction

  // compute outcome of one command and update shadow state
  task automatic bin_outcome(input hist_cmd_t c);
    hist_res_t r;
    longint eff_cnt, diff, idx, amt, e, content;
    r.status = whb_pkg::StDropped;
    r.index = '0;
    e = 0;
    content = 0;
    if (c.cmd == whb_pkg::CmdAdd) begin
      eff_cnt = (count_q > whb_pkg::MaxBins) ? whb_pkg::MaxBins : count_q;
      diff = longint'($signed(c.sample)) - lb_q;
      if (eff_cnt >= 2 && width_q != 0 && diff >= 0) begin
        idx = diff / width_q;
        if (idx < eff_cnt - 1) begin
          amt = c.use_w ? longint'($signed(c.weight)) : 65536;
          bins_q[idx] = sat48(bins_q[idx], amt);
          sum_q = sat48(sum_q, amt);
          r.status = whb_pkg::StAdded;
          r.index = idx[9:0];
          e = lb_q + idx * width_q;
          content = bins_q[idx];
        end
      end
    end else if (c.cmd == whb_pkg::CmdRead) begin
      r.status = whb_pkg::StRead;
      r.index = c.sel;
      e = lb_q + longint'(c.sel) * width_q;
      content = bins_q[c.sel];
    end else if (c.cmd == whb_pkg::CmdClear) begin
      foreach (bins_q[k]) bins_q[k] = 0;
      sum_q = 0;
      r.status = whb_pkg::StCleared;
    end
    r.edge_v = e[47:0];
    r.content = content[47:0];
    r.total = sum_q[47:0];
    r.integ = area_of(sum_q, width_q);
    expected_q.push_back(r);
  endtask

  // acceptance and prediction at the rising edge
  always @(posedge clk_i) begin
    hist_cmd_t c;
    taken <= start_i && !busy_o;
    if (start_i && !busy_o) begin
      c.cmd = command_i;
      c.sample = sample_i;
      c.use_w = use_weight_i;
      c.weight = weight_i;
      c.sel = bin_select_i;
      bin_outcome(c);
    end
  end

  // driver: bursts with random gaps, inputs move on the falling edge
  int burst_left = 4;
  int gap_left = 0;
  always @(negedge clk_i) begin
    hist_cmd_t c;
    if (!start_i || taken) begin
      if (gap_left > 0 || pending_q.size() == 0) begin
        start_i <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        c = pending_q.pop_front();
        start_i <= 1'b1;
        command_i <= c.cmd;
        sample_i <= c.sample;
        use_weight_i <= c.use_w;
        weight_i <= c.weight;
        bin_select_i <= c.sel;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    hist_res_t x;
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result, status %0d", status_o);
      end else begin
        x = expected_q.pop_front();
        if (status_o !== x.status || bin_index_o !== x.index || bin_edge_o !== x.edge_v ||
            bin_total_o !== x.content || total_weight_o !== x.total ||
            integral_o !== x.integ) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp st %0d idx %0d edge %h bin %h tot %h int %h",
                      " / got st %0d idx %0d edge %h bin %h tot %h int %h"},
                     x.status, x.index, x.edge_v, x.content, x.total, x.integ,
                     status_o, bin_index_o, bin_edge_o, bin_total_o, total_weight_o,
                     integral_o);
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == whb_pkg::RegLowerBound) lb_q = longint'($signed(val));
    else if (idx == whb_pkg::RegBinWidth) width_q = longint'(val[30:0]);
    else count_q = longint'(val[10:0]);
  endtask

  task automatic push(input logic [1:0] cmd, input logic [31:0] s, input logic uw,
                      input logic [31:0] w, input logic [9:0] sel);
    hist_cmd_t c;
    c.cmd = cmd; c.sample = s; c.use_w = uw; c.weight = w; c.sel = sel;
    pending_q.push_back(c);
  endtask

  // wait until all transactions drained, then let the pipeline settle
  task automatic drain();
    while (pending_q.size() != 0 || expected_q.size() != 0 || start_i) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  // random mix; adds mostly aimed around the configured bins
  task automatic random_items(input int n);
    longint span, b, s;
    int pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      span = (count_q > whb_pkg::MaxBins) ? whb_pkg::MaxBins : count_q;
      if (pick < 60) begin
        b = $urandom_range(0, 32'(span));
        s = lb_q + b * width_q +
            ((width_q > 1) ? $urandom_range(0, 32'(width_q - 1)) : 0);
        if ($urandom_range(0, 5) == 0) s = $urandom;
        push(whb_pkg::CmdAdd, s[31:0], 1'($urandom_range(0, 1)), $urandom,
             10'($urandom));
      end else if (pick < 90) begin
        push(whb_pkg::CmdRead, $urandom, 1'($urandom_range(0, 1)), $urandom,
             10'($urandom));
      end else if (pick < 94) begin
        push(whb_pkg::CmdClear, $urandom, 1'($urandom_range(0, 1)), $urandom,
             10'($urandom));
      end else begin
        push(CmdUnused, $urandom, 1'($urandom_range(0, 1)), $urandom, 10'($urandom));
      end
    end
    drain();
  endtask

  initial begin
    lb_q = 0; width_q = 65536; count_q = 1024; sum_q = 0;
    foreach (bins_q[k]) bins_q[k] = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // reset clearing pass
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);

    // directed, reset configuration
    push(whb_pkg::CmdAdd, 32'h0000_0000, 1'b0, 32'h0, 10'd0);
    push(whb_pkg::CmdAdd, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 10'h3FF);
    push(whb_pkg::CmdAdd, 32'h8000_0000, 1'b1, 32'h8000_0000, 10'd0);
    push(whb_pkg::CmdAdd, 32'h03FE_8000, 1'b1, 32'h7FFF_FFFF, 10'd0);
    push(whb_pkg::CmdAdd, 32'h03FE_FFFF, 1'b1, 32'h7FFF_FFFF, 10'd0);
    push(whb_pkg::CmdAdd, 32'h03FF_0000, 1'b0, 32'h0, 10'd0);
    push(whb_pkg::CmdAdd, 32'h0001_0000, 1'b1, 32'h8000_0000, 10'd0);
    push(whb_pkg::CmdAdd, 32'hFFFF_FFFF, 1'b0, 32'h0, 10'd0);
    push(whb_pkg::CmdRead, 32'h0, 1'b0, 32'h0, 10'd0);
    push(whb_pkg::CmdRead, 32'h0, 1'b0, 32'h0, 10'd1022);
    push(whb_pkg::CmdRead, 32'h0, 1'b0, 32'h0, 10'h3FF);
    push(CmdUnused, 32'h0, 1'b0, 32'h0, 10'd0);
    push(whb_pkg::CmdClear, 32'h0, 1'b0, 32'h0, 10'd0);
    push(whb_pkg::CmdRead, 32'h0, 1'b0, 32'h0, 10'd1022);
    drain();
    random_items(100);

    // narrowest histogram at the lowest bound
    write_reg(whb_pkg::RegLowerBound, 32'h8000_0000);
    write_reg(whb_pkg::RegBinWidth, 32'h0000_0001);
    write_reg(whb_pkg::RegBinCount, 32'd2);
    push(whb_pkg::CmdAdd, 32'h8000_0000, 1'b0, 32'h0, 10'd0);
    push(whb_pkg::CmdAdd, 32'h8000_0001, 1'b0, 32'h0, 10'd0);
    drain();
    random_items(90);

    // widest bins from the top bound
    write_reg(whb_pkg::RegLowerBound, 32'h7FFF_FFFF);
    write_reg(whb_pkg::RegBinWidth, 32'h7FFF_FFFF);
    write_reg(whb_pkg::RegBinCount, 32'd1024);
    random_items(80);

    // too few edges, then zero width, then an oversized count
    write_reg(whb_pkg::RegBinCount, 32'd1);
    write_reg(whb_pkg::RegLowerBound, 32'hFFF0_0000);
    write_reg(whb_pkg::RegBinWidth, 32'h0000_4000);
    random_items(40);
    write_reg(whb_pkg::RegBinCount, 32'd0);
    random_items(20);
    write_reg(whb_pkg::RegBinWidth, 32'h8000_0000);
    write_reg(whb_pkg::RegBinCount, 32'd16);
    random_items(30);
    write_reg(whb_pkg::RegBinWidth, 32'h0000_8000);
    write_reg(whb_pkg::RegBinCount, 32'h7FF);
    random_items(80);

    // random settings, mostly small counts
    for (int p = 0; p < 5; p++) begin
      write_reg(whb_pkg::RegLowerBound, $urandom);
      write_reg(whb_pkg::RegBinWidth, $urandom_range(1, 32'h0004_0000));
      write_reg(whb_pkg::RegBinCount, (p == 4) ? $urandom : $urandom_range(2, 40));
      random_items(40);
    end

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
